>>> hw/rtl/keyed_debounce_table_defines.svh
// Assertion macros for the debounce table RTL.
`ifndef KEYED_DEBOUNCE_TABLE_DEFINES_SVH
`define KEYED_DEBOUNCE_TABLE_DEFINES_SVH

// Same-cycle implication, checked on the rising edge of clock outside reset.
`define KDT_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on the rising edge of clock outside reset.
`define KDT_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/kdt_pkg.sv
// Types and codes shared by the debounce table modules.
package kdt_pkg;

   // Request codes carried on req_type.
   typedef enum logic [2:0] {
      REQ_REGISTER = 3'd0,
      REQ_UPDATE   = 3'd1,
      REQ_GET      = 3'd2,
      REQ_FIND     = 3'd3,
      REQ_DELETE   = 3'd4,
      REQ_CLEAR    = 3'd5,
      REQ_ADVANCE  = 3'd6,
      REQ_SCAN     = 3'd7
   } req_code_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_code_type;

   // Table update commands issued by the sequencer.
   typedef enum logic [2:0] {
      TOP_NONE,
      TOP_CREATE,
      TOP_RESTAMP,
      TOP_UPDATE,
      TOP_FREE,
      TOP_CLEAR,
      TOP_DONE,
      TOP_ADVANCE
   } tbl_op_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_APPLY,
      S_SCAN,
      S_FLUSH
   } ctrl_state_type;

   // Per-entry flags read from the table.
   typedef struct packed {
      logic used;
      logic has_value;
      logic done;
   } entry_flags_type;

   // Results of the shared compare unit.
   typedef struct packed {
      logic match;
      logic due;
      logic quiet_nz;
   } cmp_res_type;

endpackage

>>> hw/rtl/keyed_debounce_table.sv
// Top level of the keyed trailing-edge debounce table.
// Lookups walk the table slot by slot up to the match or the last slot, then pass through
// apply, flush and the output register; clear and advance go straight to apply and flush.
// A scan walks every slot before its flush; rsp_ready holding off a waiting result delays
// any request. The next request is accepted as the final result is presented, and not
// before; synchronous reset empties table and time.
module keyed_debounce_table #(
   parameter int ENTRIES    = 32,
   parameter int VALUE_BITS = 32,
   parameter int KEY_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [15:0] req_group_key,
   input  logic [31:0] req_new_value,
   input  logic [31:0] req_quiet_ms,
   input  logic [15:0] req_elapsed_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_hit,
   output logic [15:0] rsp_out_key,
   output logic [31:0] rsp_out_value,
   output logic        rsp_last
);
   import kdt_pkg::*;

   localparam int KEY_W = (KEY_BITS < 16) ? KEY_BITS : 16;
   localparam int VAL_W = (VALUE_BITS < 32) ? VALUE_BITS : 32;
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   tbl_op_type       tbl_op;
   logic [IDX_W-1:0] wr_idx, rd_idx;
   logic [KEY_W-1:0] wr_key, rd_key;
   logic [VAL_W-1:0] wr_value, rd_value;
   logic [31:0]      wr_quiet, rd_quiet;
   logic [15:0]      adv_ms;
   logic [63:0]      rd_stamp, time_now;
   entry_flags_type  rd_flags;
   cmp_res_type      cmp;

   kdt_ctrl #(
      .ENTRIES (ENTRIES),
      .KEY_W   (KEY_W),
      .VAL_W   (VAL_W),
      .IDX_W   (IDX_W)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_group_key  (req_group_key),
      .req_new_value  (req_new_value),
      .req_quiet_ms   (req_quiet_ms),
      .req_elapsed_ms (req_elapsed_ms),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_hit        (rsp_hit),
      .rsp_out_key    (rsp_out_key),
      .rsp_out_value  (rsp_out_value),
      .rsp_last       (rsp_last),
      .tbl_op         (tbl_op),
      .wr_idx         (wr_idx),
      .rd_idx         (rd_idx),
      .wr_key         (wr_key),
      .wr_value       (wr_value),
      .wr_quiet       (wr_quiet),
      .adv_ms         (adv_ms),
      .rd_flags       (rd_flags),
      .rd_key         (rd_key),
      .rd_value       (rd_value),
      .cmp            (cmp)
   );

   kdt_table #(
      .ENTRIES (ENTRIES),
      .KEY_W   (KEY_W),
      .VAL_W   (VAL_W),
      .IDX_W   (IDX_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .op       (tbl_op),
      .wr_idx   (wr_idx),
      .wr_key   (wr_key),
      .wr_value (wr_value),
      .wr_quiet (wr_quiet),
      .adv_ms   (adv_ms),
      .rd_idx   (rd_idx),
      .rd_flags (rd_flags),
      .rd_key   (rd_key),
      .rd_value (rd_value),
      .rd_stamp (rd_stamp),
      .rd_quiet (rd_quiet),
      .time_now (time_now)
   );

   kdt_cmp #(
      .KEY_W (KEY_W)
   ) u_cmp (
      .flags    (rd_flags),
      .ent_key  (rd_key),
      .req_key  (wr_key),
      .stamp    (rd_stamp),
      .quiet    (rd_quiet),
      .time_now (time_now),
      .res      (cmp)
   );

endmodule

>>> hw/rtl/kdt_table.sv
// Entry storage, per-entry flags and the millisecond time counter.
module kdt_table #(
   parameter int ENTRIES = 32,
   parameter int KEY_W   = 16,
   parameter int VAL_W   = 32,
   parameter int IDX_W   = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  kdt_pkg::tbl_op_type      op,
   input  logic [IDX_W-1:0]         wr_idx,
   input  logic [KEY_W-1:0]         wr_key,
   input  logic [VAL_W-1:0]         wr_value,
   input  logic [31:0]              wr_quiet,
   input  logic [15:0]              adv_ms,
   input  logic [IDX_W-1:0]         rd_idx,
   output kdt_pkg::entry_flags_type rd_flags,
   output logic [KEY_W-1:0]         rd_key,
   output logic [VAL_W-1:0]         rd_value,
   output logic [63:0]              rd_stamp,
   output logic [31:0]              rd_quiet,
   output logic [63:0]              time_now
);
   import kdt_pkg::*;

   logic [KEY_W-1:0]   entry_key_ff   [ENTRIES];
   logic [VAL_W-1:0]   entry_value_ff [ENTRIES];
   logic [63:0]        entry_stamp_ff [ENTRIES];
   logic [31:0]        entry_quiet_ff [ENTRIES];
   logic [ENTRIES-1:0] used_ff, used_in;
   logic [ENTRIES-1:0] has_value_ff, has_value_in;
   logic [ENTRIES-1:0] done_ff, done_in;
   logic [63:0]        time_ff, time_in;
   logic               key_we, value_we, stamp_we, quiet_we;
   logic [VAL_W-1:0]   value_wdata;

   // Write enables for the payload arrays.
   assign key_we      = (op == TOP_CREATE);
   assign value_we    = (op == TOP_CREATE) || (op == TOP_UPDATE);
   assign stamp_we    = (op == TOP_CREATE) || (op == TOP_RESTAMP) || (op == TOP_UPDATE);
   assign quiet_we    = (op == TOP_CREATE) || (op == TOP_RESTAMP);
   assign value_wdata = (op == TOP_CREATE) ? '0 : wr_value;

   // Payload arrays hold no reset; a slot is always fully written when created.
   always_ff @(posedge clock) begin
      if (key_we) begin
         entry_key_ff[wr_idx] <= wr_key;
      end
      if (value_we) begin
         entry_value_ff[wr_idx] <= value_wdata;
      end
      if (stamp_we) begin
         entry_stamp_ff[wr_idx] <= time_ff;
      end
      if (quiet_we) begin
         entry_quiet_ff[wr_idx] <= wr_quiet;
      end
   end

   // Next values of the flag vectors and the time counter.
   always_comb begin
      used_in      = used_ff;
      has_value_in = has_value_ff;
      done_in      = done_ff;
      time_in      = time_ff;
      unique case (op)
         TOP_CREATE: begin
            used_in[wr_idx]      = 1'b1;
            has_value_in[wr_idx] = 1'b0;
            done_in[wr_idx]      = 1'b0;
         end
         TOP_UPDATE: begin
            has_value_in[wr_idx] = 1'b1;
            done_in[wr_idx]      = 1'b0;
         end
         TOP_FREE: begin
            used_in[wr_idx]      = 1'b0;
            has_value_in[wr_idx] = 1'b0;
            done_in[wr_idx]      = 1'b0;
         end
         TOP_CLEAR: begin
            used_in      = '0;
            has_value_in = '0;
            done_in      = '0;
         end
         TOP_DONE: begin
            done_in[wr_idx] = 1'b1;
         end
         TOP_ADVANCE: begin
            time_in = time_ff + 64'(adv_ms);
         end
         TOP_NONE, TOP_RESTAMP: begin
         end
         default: begin
         end
      endcase
   end

   // Flag and time registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         has_value_ff <= '0;
         done_ff      <= '0;
         time_ff      <= '0;
      end else begin
         used_ff      <= used_in;
         has_value_ff <= has_value_in;
         done_ff      <= done_in;
         time_ff      <= time_in;
      end
   end

   // Single read port at the sequencer's slot index.
   assign rd_flags = '{used: used_ff[rd_idx], has_value: has_value_ff[rd_idx],
                       done: done_ff[rd_idx]};
   assign rd_key   = entry_key_ff[rd_idx];
   assign rd_value = entry_value_ff[rd_idx];
   assign rd_stamp = entry_stamp_ff[rd_idx];
   assign rd_quiet = entry_quiet_ff[rd_idx];
   assign time_now = time_ff;

endmodule

>>> hw/rtl/kdt_cmp.sv
// Shared compare unit: key match and due-time check for one slot.
module kdt_cmp #(
   parameter int KEY_W = 16
) (
   input  kdt_pkg::entry_flags_type flags,
   input  logic [KEY_W-1:0]         ent_key,
   input  logic [KEY_W-1:0]         req_key,
   input  logic [63:0]              stamp,
   input  logic [31:0]              quiet,
   input  logic [63:0]              time_now,
   output kdt_pkg::cmp_res_type     res
);
   import kdt_pkg::*;

   logic [64:0] limit;

   // The due time carries out of 64 bits on overflow; such an entry is never due.
   assign limit        = {1'b0, stamp} + 65'(quiet);
   assign res.due      = !limit[64] && (time_now > limit[63:0]);
   assign res.match    = flags.used && (ent_key == req_key);
   assign res.quiet_nz = (quiet != '0);

endmodule

>>> hw/rtl/kdt_ctrl.sv
// Sequencer: walks the table slot by slot and builds the result stream.
`include "keyed_debounce_table_defines.svh"

module kdt_ctrl #(
   parameter int ENTRIES = 32,
   parameter int KEY_W   = 16,
   parameter int VAL_W   = 32,
   parameter int IDX_W   = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [2:0]               req_type,
   input  logic [15:0]              req_group_key,
   input  logic [31:0]              req_new_value,
   input  logic [31:0]              req_quiet_ms,
   input  logic [15:0]              req_elapsed_ms,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic                     rsp_hit,
   output logic [15:0]              rsp_out_key,
   output logic [31:0]              rsp_out_value,
   output logic                     rsp_last,
   output kdt_pkg::tbl_op_type      tbl_op,
   output logic [IDX_W-1:0]         wr_idx,
   output logic [IDX_W-1:0]         rd_idx,
   output logic [KEY_W-1:0]         wr_key,
   output logic [VAL_W-1:0]         wr_value,
   output logic [31:0]              wr_quiet,
   output logic [15:0]              adv_ms,
   input  kdt_pkg::entry_flags_type rd_flags,
   input  logic [KEY_W-1:0]         rd_key,
   input  logic [VAL_W-1:0]         rd_value,
   input  kdt_pkg::cmp_res_type     cmp
);
   import kdt_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   ctrl_state_type  state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             hit_ff, hit_in;
   logic             free_ok_ff, free_ok_in;
   req_code_type     code_ff, code_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [VAL_W-1:0] value_ff, value_in;
   logic [31:0]      quiet_ff, quiet_in;
   logic [15:0]      elapsed_ff, elapsed_in;
   logic             pend_valid_ff, pend_valid_in;
   status_code_type  pend_status_ff, pend_status_in;
   logic             pend_hit_ff, pend_hit_in;
   logic [KEY_W-1:0] pend_key_ff, pend_key_in;
   logic [VAL_W-1:0] pend_value_ff, pend_value_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_code_type  rsp_status_ff, rsp_status_in;
   logic             rsp_hit_ff, rsp_hit_in;
   logic [15:0]      rsp_key_ff, rsp_key_in;
   logic [31:0]      rsp_value_ff, rsp_value_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             accept, out_free, at_last;
   logic             scan_cand, scan_emit, stall;

   // Handshake and walk conditions.
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign at_last   = (idx_ff == LAST_IDX);
   assign scan_cand = rd_flags.used && !rd_flags.done && cmp.due;
   assign scan_emit = scan_cand && rd_flags.has_value;
   assign stall     = scan_emit && pend_valid_ff && !out_free;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               priority if ((req_code_type'(req_type) == REQ_CLEAR) ||
                            (req_code_type'(req_type) == REQ_ADVANCE)) begin
                  state_in = S_APPLY;
               end else if (req_code_type'(req_type) == REQ_SCAN) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_WALK;
               end
            end
         end
         S_WALK: begin
            if (cmp.match || at_last) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            state_in = S_FLUSH;
         end
         S_SCAN: begin
            if (!stall && at_last) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Datapath, table commands and result register loads.
   always_comb begin
      idx_in         = idx_ff;
      free_idx_in    = free_idx_ff;
      hit_in         = hit_ff;
      free_ok_in     = free_ok_ff;
      code_in        = code_ff;
      key_in         = key_ff;
      value_in       = value_ff;
      quiet_in       = quiet_ff;
      elapsed_in     = elapsed_ff;
      pend_valid_in  = pend_valid_ff;
      pend_status_in = pend_status_ff;
      pend_hit_in    = pend_hit_ff;
      pend_key_in    = pend_key_ff;
      pend_value_in  = pend_value_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_key_in     = rsp_key_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_last_in    = rsp_last_ff;
      tbl_op         = TOP_NONE;
      wr_idx         = idx_ff;
      unique case (state_ff)
         // Capture the request and start the walk at slot zero.
         S_IDLE: begin
            if (accept) begin
               code_in       = req_code_type'(req_type);
               key_in        = req_group_key[KEY_W-1:0];
               value_in      = req_new_value[VAL_W-1:0];
               quiet_in      = req_quiet_ms;
               elapsed_in    = req_elapsed_ms;
               idx_in        = '0;
               hit_in        = 1'b0;
               free_ok_in    = 1'b0;
               pend_valid_in = 1'b0;
            end
         end
         // Look for the key; remember the lowest free slot on the way.
         S_WALK: begin
            if (cmp.match) begin
               hit_in = 1'b1;
            end else begin
               if (!rd_flags.used && !free_ok_ff) begin
                  free_ok_in  = 1'b1;
                  free_idx_in = idx_ff;
               end
               if (!at_last) begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         // Act on the slot found (idx_ff still points at it) and form the result.
         S_APPLY: begin
            pend_valid_in  = 1'b1;
            pend_hit_in    = 1'b0;
            pend_status_in = ST_OK;
            unique case (code_ff)
               REQ_REGISTER: begin
                  priority if (hit_ff) begin
                     tbl_op = TOP_RESTAMP;
                  end else if (free_ok_ff) begin
                     tbl_op = TOP_CREATE;
                     wr_idx = free_idx_ff;
                  end else begin
                     pend_status_in = ST_FULL;
                  end
               end
               REQ_UPDATE: begin
                  if (hit_ff) begin
                     tbl_op = TOP_UPDATE;
                  end else begin
                     pend_status_in = ST_MISS;
                  end
               end
               REQ_GET: begin
                  if (hit_ff && cmp.quiet_nz && cmp.due) begin
                     pend_hit_in   = 1'b1;
                     pend_key_in   = rd_key;
                     pend_value_in = rd_value;
                  end else begin
                     pend_status_in = ST_MISS;
                  end
               end
               REQ_FIND: begin
                  if (!hit_ff) begin
                     pend_status_in = ST_MISS;
                  end
               end
               REQ_DELETE: begin
                  if (hit_ff) begin
                     tbl_op = TOP_FREE;
                  end else begin
                     pend_status_in = ST_MISS;
                  end
               end
               REQ_CLEAR: begin
                  tbl_op = TOP_CLEAR;
               end
               REQ_ADVANCE: begin
                  tbl_op = TOP_ADVANCE;
               end
               REQ_SCAN: begin
                  pend_status_in = ST_MISS;
               end
               default: begin
                  pend_status_in = ST_MISS;
               end
            endcase
         end
         // Mark due entries done; an emitted entry waits in the pending slot
         // until the next one shows it was not the final transfer.
         S_SCAN: begin
            if (!stall) begin
               if (scan_cand) begin
                  tbl_op = TOP_DONE;
               end
               if (scan_emit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = pend_status_ff;
                     rsp_hit_in    = pend_hit_ff;
                     rsp_key_in    = 16'(pend_key_ff);
                     rsp_value_in  = 32'(pend_value_ff);
                     rsp_last_in   = 1'b0;
                  end
                  pend_valid_in  = 1'b1;
                  pend_status_in = ST_OK;
                  pend_hit_in    = 1'b1;
                  pend_key_in    = rd_key;
                  pend_value_in  = rd_value;
               end
               if (!at_last) begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         // Final transfer of the request; an empty scan reports a miss.
         S_FLUSH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = 1'b1;
               rsp_status_in = pend_valid_ff ? pend_status_ff : ST_MISS;
               rsp_hit_in    = pend_valid_ff && pend_hit_ff;
               rsp_key_in    = (pend_valid_ff && pend_hit_ff) ? 16'(pend_key_ff) : '0;
               rsp_value_in  = (pend_valid_ff && pend_hit_ff) ? 32'(pend_value_ff) : '0;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         hit_ff        <= 1'b0;
         free_ok_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         hit_ff        <= hit_in;
         free_ok_ff    <= free_ok_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      free_idx_ff    <= free_idx_in;
      code_ff        <= code_in;
      key_ff         <= key_in;
      value_ff       <= value_in;
      quiet_ff       <= quiet_in;
      elapsed_ff     <= elapsed_in;
      pend_status_ff <= pend_status_in;
      pend_hit_ff    <= pend_hit_in;
      pend_key_ff    <= pend_key_in;
      pend_value_ff  <= pend_value_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_key_ff     <= rsp_key_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // Table access and result ports.
   assign rd_idx        = idx_ff;
   assign wr_key        = key_ff;
   assign wr_value      = value_ff;
   assign wr_quiet      = quiet_ff;
   assign adv_ms        = elapsed_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_out_key   = rsp_key_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_last      = rsp_last_ff;

   // Checks on the sequencer and the result register.
   `KDT_ASSERT_IMP(a_hit_is_ok, rsp_valid_ff && rsp_hit_ff, rsp_status_ff == ST_OK, "hit with bad status")
   `KDT_ASSERT_IMP(a_miss_zero, rsp_valid_ff && !rsp_hit_ff, (rsp_key_ff == '0) && (rsp_value_ff == '0), "miss carries data")
   `KDT_ASSERT_NXT(a_busy_after_accept, accept, !req_ready, "ready after accept")
   `KDT_ASSERT_IMP(a_done_only_due, tbl_op == TOP_DONE, (state_ff == S_SCAN) && scan_cand, "done on entry not due")

endmodule

>>> sim/kdt_reply_checker.sv
// Reply checker for the keyed debounce table: predicts every reply and compares it.
`timescale 1ns / 100ps
module kdt_reply_checker #(
   parameter int ENTRIES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [15:0] req_group_key,
   input  logic [31:0] req_new_value,
   input  logic [31:0] req_quiet_ms,
   input  logic [15:0] req_elapsed_ms,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic        rsp_hit,
   input  logic [15:0] rsp_out_key,
   input  logic [31:0] rsp_out_value,
   input  logic        rsp_last,
   output int          mismatch_count,
   output int          outstanding
);
   import kdt_pkg::*;

   typedef struct {
      status_code_type status;
      logic            hit;
      logic [15:0]     key;
      logic [31:0]     value;
      logic            last;
   } reply_type;

   // Shadow copy of the table and the millisecond counter.
   logic        slot_used      [ENTRIES];
   logic [15:0] slot_key       [ENTRIES];
   logic [31:0] slot_value     [ENTRIES];
   logic        slot_has_value [ENTRIES];
   logic [63:0] slot_stamp     [ENTRIES];
   logic [31:0] slot_quiet     [ENTRIES];
   logic        slot_done      [ENTRIES];
   logic [63:0] now_ms;

   reply_type pending_replies[$];

   function automatic int slot_of(logic [15:0] key);
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_used[i] && slot_key[i] == key) return i;
      end
      return -1;
   endfunction

   // An entry is due once the counter is past stamp plus quiet time; a sum that
   // does not fit in 64 bits never comes due.
   function automatic logic slot_due(int i);
      logic [64:0] deadline;
      deadline = {1'b0, slot_stamp[i]} + {33'd0, slot_quiet[i]};
      return !deadline[64] && (now_ms > deadline[63:0]);
   endfunction

   function automatic void push_reply(status_code_type status, logic hit, logic [15:0] key,
                                      logic [31:0] value, logic last);
      reply_type r;
      r.status = status;
      r.hit    = hit;
      r.key    = key;
      r.value  = value;
      r.last   = last;
      pending_replies.push_back(r);
   endfunction

   // Applies one request to the shadow table and queues the replies it causes.
   function automatic void table_request(req_code_type code, logic [15:0] key,
                                         logic [31:0] value, logic [31:0] quiet,
                                         logic [15:0] elapsed);
      int idx;
      int free_idx;
      int emitted[$];
      idx = slot_of(key);
      case (code)
         REQ_REGISTER: begin
            free_idx = -1;
            for (int j = ENTRIES - 1; j >= 0; j--) begin
               if (!slot_used[j]) free_idx = j;
            end
            if (idx < 0 && free_idx < 0) begin
               push_reply(ST_FULL, 1'b0, '0, '0, 1'b1);
            end else begin
               if (idx < 0) begin
                  idx = free_idx;
                  slot_used[idx]      = 1'b1;
                  slot_key[idx]       = key;
                  slot_value[idx]     = '0;
                  slot_has_value[idx] = 1'b0;
                  slot_done[idx]      = 1'b0;
               end
               slot_stamp[idx] = now_ms;
               slot_quiet[idx] = quiet;
               push_reply(ST_OK, 1'b0, '0, '0, 1'b1);
            end
         end
         REQ_UPDATE: begin
            if (idx < 0) begin
               push_reply(ST_MISS, 1'b0, '0, '0, 1'b1);
            end else begin
               slot_value[idx]     = value;
               slot_has_value[idx] = 1'b1;
               slot_stamp[idx]     = now_ms;
               slot_done[idx]      = 1'b0;
               push_reply(ST_OK, 1'b0, '0, '0, 1'b1);
            end
         end
         REQ_GET: begin
            if (idx >= 0 && slot_quiet[idx] != 0 && slot_due(idx))
               push_reply(ST_OK, 1'b1, slot_key[idx], slot_value[idx], 1'b1);
            else
               push_reply(ST_MISS, 1'b0, '0, '0, 1'b1);
         end
         REQ_FIND: begin
            push_reply(idx >= 0 ? ST_OK : ST_MISS, 1'b0, '0, '0, 1'b1);
         end
         REQ_DELETE: begin
            if (idx >= 0) begin
               slot_used[idx]      = 1'b0;
               slot_has_value[idx] = 1'b0;
               slot_done[idx]      = 1'b0;
            end
            push_reply(idx >= 0 ? ST_OK : ST_MISS, 1'b0, '0, '0, 1'b1);
         end
         REQ_CLEAR: begin
            for (int j = 0; j < ENTRIES; j++) begin
               slot_used[j]      = 1'b0;
               slot_has_value[j] = 1'b0;
               slot_done[j]      = 1'b0;
            end
            push_reply(ST_OK, 1'b0, '0, '0, 1'b1);
         end
         REQ_ADVANCE: begin
            now_ms = now_ms + {48'd0, elapsed};
            push_reply(ST_OK, 1'b0, '0, '0, 1'b1);
         end
         default: begin
            // Scan: mark due entries done and emit those that carry a value.
            for (int j = 0; j < ENTRIES; j++) begin
               if (slot_used[j] && !slot_done[j] && slot_due(j)) begin
                  slot_done[j] = 1'b1;
                  if (slot_has_value[j]) emitted.push_back(j);
               end
            end
            if (emitted.size() == 0) begin
               push_reply(ST_MISS, 1'b0, '0, '0, 1'b1);
            end else begin
               foreach (emitted[n]) begin
                  push_reply(ST_OK, 1'b1, slot_key[emitted[n]], slot_value[emitted[n]],
                             n == emitted.size() - 1);
               end
            end
         end
      endcase
   endfunction

   // Replies are checked before the request of the same edge is predicted.
   always @(posedge clock) begin
      int errs;
      reply_type want;
      errs = 0;
      if (reset) begin
         pending_replies.delete();
         for (int j = 0; j < ENTRIES; j++) begin
            slot_used[j]      = 1'b0;
            slot_has_value[j] = 1'b0;
            slot_done[j]      = 1'b0;
         end
         now_ms = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_replies.size() == 0) begin
               $error("reply transfer with none expected: status %0d key %h value %h",
                      rsp_status, rsp_out_key, rsp_out_value);
               errs++;
            end else begin
               want = pending_replies.pop_front();
               if (rsp_status !== want.status) begin
                  $error("rsp_status: expected %0d, got %0d", want.status, rsp_status);
                  errs++;
               end
               if (rsp_hit !== want.hit) begin
                  $error("rsp_hit: expected %0d, got %0d", want.hit, rsp_hit);
                  errs++;
               end
               if (rsp_out_key !== want.key) begin
                  $error("rsp_out_key: expected %h, got %h", want.key, rsp_out_key);
                  errs++;
               end
               if (rsp_out_value !== want.value) begin
                  $error("rsp_out_value: expected %h, got %h", want.value, rsp_out_value);
                  errs++;
               end
               if (rsp_last !== want.last) begin
                  $error("rsp_last: expected %0d, got %0d", want.last, rsp_last);
                  errs++;
               end
            end
         end
         if (req_valid && req_ready) begin
            table_request(req_code_type'(req_type), req_group_key, req_new_value,
                          req_quiet_ms, req_elapsed_ms);
         end
      end
      mismatch_count <= mismatch_count + errs;
      outstanding    <= pending_replies.size();
   end

endmodule

>>> sim/keyed_debounce_table_tb.sv
// Testbench top for the keyed debounce table: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps
module keyed_debounce_table_tb;
   import kdt_pkg::*;

   localparam int TABLE_SLOTS   = 32;
   localparam int RANDOM_ITEMS  = 253;
   localparam int KEY_POOL      = 10;
   localparam int HOLD_AT       = 120;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 64;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic [2:0]  req_type       = REQ_FIND;
   logic [15:0] req_group_key  = '0;
   logic [31:0] req_new_value  = '0;
   logic [31:0] req_quiet_ms   = '0;
   logic [15:0] req_elapsed_ms = '0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_hit;
   logic [15:0] rsp_out_key;
   logic [31:0] rsp_out_value;
   logic        rsp_last;

   int          mismatch_count;
   int          outstanding;
   int          issued            = 0;
   int          accepted_requests = 0;
   int          sender_idle_pct   = 0;
   int          rsp_stall_pct     = 0;
   int          hold_left         = 0;
   logic        hold_taken        = 1'b0;
   logic [15:0] key_pool [KEY_POOL];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   keyed_debounce_table #(
      .ENTRIES   (TABLE_SLOTS),
      .VALUE_BITS(32),
      .KEY_BITS  (16)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_group_key (req_group_key),
      .req_new_value (req_new_value),
      .req_quiet_ms  (req_quiet_ms),
      .req_elapsed_ms(req_elapsed_ms),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_hit       (rsp_hit),
      .rsp_out_key   (rsp_out_key),
      .rsp_out_value (rsp_out_value),
      .rsp_last      (rsp_last)
   );

   kdt_reply_checker #(.ENTRIES(TABLE_SLOTS)) reply_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_group_key (req_group_key),
      .req_new_value (req_new_value),
      .req_quiet_ms  (req_quiet_ms),
      .req_elapsed_ms(req_elapsed_ms),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_hit       (rsp_hit),
      .rsp_out_key   (rsp_out_key),
      .rsp_out_value (rsp_out_value),
      .rsp_last      (rsp_last),
      .mismatch_count(mismatch_count),
      .outstanding   (outstanding)
   );

   // Reply side: random stalls, plus one long hold-off that backs the block up.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_taken && accepted_requests >= HOLD_AT) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Offers one request and returns at the edge where its transfer takes place.
   task automatic send_request(req_code_type code, logic [15:0] key, logic [31:0] value,
                               logic [31:0] quiet, logic [15:0] elapsed);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= code;
      req_group_key  <= key;
      req_new_value  <= value;
      req_quiet_ms   <= quiet;
      req_elapsed_ms <= elapsed;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      issued++;
      accepted_requests <= issued;
   endtask

   // One weighted random request, mostly on a small set of keys so that lookups hit.
   task automatic send_random_request();
      int          pick;
      req_code_type code;
      logic [15:0] key;
      logic [31:0] quiet;
      logic [15:0] elapsed;
      pick = $urandom_range(99);
      if (pick < 18)      code = REQ_REGISTER;
      else if (pick < 36) code = REQ_UPDATE;
      else if (pick < 50) code = REQ_GET;
      else if (pick < 58) code = REQ_FIND;
      else if (pick < 65) code = REQ_DELETE;
      else if (pick < 67) code = REQ_CLEAR;
      else if (pick < 82) code = REQ_ADVANCE;
      else                code = REQ_SCAN;
      if ($urandom_range(99) < 85) key = key_pool[$urandom_range(KEY_POOL - 1)];
      else                         key = 16'($urandom_range(65535));
      pick = $urandom_range(9);
      if (pick == 0)     quiet = '0;
      else if (pick < 8) quiet = $urandom_range(40);
      else               quiet = $urandom;
      if ($urandom_range(9) < 8) elapsed = 16'($urandom_range(30));
      else                       elapsed = 16'($urandom_range(65535));
      send_request(code, key, $urandom, quiet, elapsed);
   endtask

   // Fills every slot, overflows the table, gives every entry a value and scans
   // them all due at once.
   task automatic fill_table();
      logic [15:0] base;
      base = 16'($urandom_range(65535));
      send_request(REQ_CLEAR, base, $urandom, $urandom, '0);
      for (int j = 0; j <= TABLE_SLOTS; j++) begin
         send_request(REQ_REGISTER, base + 16'(j), $urandom, $urandom_range(6), '0);
      end
      send_request(REQ_REGISTER, base, $urandom, 32'd3, '0);
      for (int j = 0; j < TABLE_SLOTS; j++) begin
         send_request(REQ_UPDATE, base + 16'(j), $urandom, $urandom, '0);
      end
      send_request(REQ_ADVANCE, base, $urandom, '0, 16'd20);
      send_request(REQ_SCAN, base, $urandom, '0, '0);
   endtask

   // Idling mix for each quarter of the random part.
   task automatic set_pacing(int quarter);
      case (quarter)
         0:       begin sender_idle_pct = 0;  rsp_stall_pct <= 0;  end
         1:       begin sender_idle_pct = 55; rsp_stall_pct <= 0;  end
         2:       begin sender_idle_pct = 0;  rsp_stall_pct <= 55; end
         default: begin sender_idle_pct = 29; rsp_stall_pct <= 29; end
      endcase
   endtask

   initial begin
      int directed_end;
      int bursts;
      key_pool[0] = 16'h0000;
      key_pool[1] = 16'hFFFF;
      for (int j = 2; j < KEY_POOL; j++) key_pool[j] = 16'($urandom_range(65535));
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty table, misses, extremes and the due rules.
      send_request(REQ_SCAN,     16'h0000, '0, '0, '0);
      send_request(REQ_GET,      16'h0000, '0, '0, '0);
      send_request(REQ_UPDATE,   16'hFFFF, 32'hFFFF_FFFF, '0, '0);
      send_request(REQ_FIND,     16'hFFFF, '0, '0, '0);
      send_request(REQ_DELETE,   16'h0000, '0, '0, '0);
      send_request(REQ_REGISTER, 16'h0000, '0, 32'd0, '0);
      send_request(REQ_REGISTER, 16'hFFFF, '0, 32'd5, '0);
      send_request(REQ_REGISTER, 16'h1234, '0, 32'hFFFF_FFFF, 16'hFFFF);
      send_request(REQ_UPDATE,   16'h0000, 32'hFFFF_FFFF, '0, '0);
      send_request(REQ_UPDATE,   16'hFFFF, 32'hA5A5_A5A5, '0, '0);
      send_request(REQ_UPDATE,   16'h1234, 32'h5A5A_5A5A, '0, '0);
      send_request(REQ_GET,      16'hFFFF, '0, '0, '0);
      send_request(REQ_FIND,     16'hFFFF, '0, '0, '0);
      send_request(REQ_ADVANCE,  16'h0000, '0, '0, 16'h0000);
      send_request(REQ_ADVANCE,  16'h0000, '0, '0, 16'hFFFF);
      // Zero quiet time never answers a get; the long quiet time is not due yet.
      send_request(REQ_GET,      16'h0000, '0, '0, '0);
      send_request(REQ_GET,      16'hFFFF, '0, '0, '0);
      send_request(REQ_GET,      16'h1234, '0, '0, '0);
      send_request(REQ_SCAN,     16'h0000, '0, '0, '0);
      send_request(REQ_SCAN,     16'h0000, '0, '0, '0);
      // A refresh keeps the done flag; an update clears it again.
      send_request(REQ_REGISTER, 16'hFFFF, '0, 32'd5, '0);
      send_request(REQ_UPDATE,   16'hFFFF, 32'h0000_0001, '0, '0);
      send_request(REQ_ADVANCE,  16'h0000, '0, '0, 16'd6);
      send_request(REQ_SCAN,     16'h0000, '0, '0, '0);
      send_request(REQ_DELETE,   16'h0000, '0, '0, '0);
      send_request(REQ_CLEAR,    16'h0000, '0, '0, '0);
      send_request(REQ_FIND,     16'hFFFF, '0, '0, '0);

      // Random part, with two full-table bursts along the way.
      directed_end = issued;
      bursts = 0;
      while (issued - directed_end < RANDOM_ITEMS) begin
         set_pacing((issued - directed_end) * 4 / RANDOM_ITEMS);
         if (bursts < 2 && issued - directed_end >= (bursts + 1) * RANDOM_ITEMS / 3) begin
            fill_table();
            bursts++;
         end else begin
            send_random_request();
         end
      end
      req_valid     <= 1'b0;
      rsp_stall_pct <= 0;

      // Drain, then give a stray reply time to show up.
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
